FILE: src/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

	localparam int MAX_CAPACITY = 256;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_req;
		logic       end_of_input;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [1:0] error_code;
		logic [8:0] decoded_length;
		logic       last;
	} out_t;

	typedef enum logic [2:0] {
		PH_PLAIN  = 3'd0,
		PH_ESC    = 3'd1,
		PH_HEX1   = 3'd2,
		PH_LOW_BS = 3'd3,
		PH_LOW_U  = 3'd4,
		PH_HEX2   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_BYTES,
		ACT_CLOSE,
		ACT_ERROR
	} act_t;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_MALFORMED = 2'd1;
	localparam logic [1:0] ERR_TOO_LONG  = 2'd2;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int         BUF_DEPTH = 5;
	localparam logic [8:0] CAP_RESET = 9'd256;

endpackage

`default_nettype wire

FILE: src/json_string_unescaper.sv
// Results are registered in the result buffer and presented from its head.
// Throughput: one input beat per cycle while at most one result beat is waiting;
// results leave one beat per cycle unless out_stall, up to four per input beat (UTF-8 sequence).
// The five-entry result buffer sets the input stall; decode is a single pass.
// Reset: idle, buffer empty, string_capacity = 256.
`default_nettype none

module json_string_unescaper (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  jsu_pkg::in_t      in_data,
	output logic              out_valid,
	input  wire               out_stall,
	output jsu_pkg::out_t     out_data,
	input  wire               cfg_we,
	input  wire  [8:0]        cfg_wdata
);

	logic [8:0]       cap_q;
	logic             active_q;
	jsu_pkg::phase_t  phase_q;
	logic [1:0]       hcnt_q;
	logic [15:0]      acc_q;
	logic [9:0]       hs_q;
	logic [8:0]       bc_q;

	logic             nx_active;
	jsu_pkg::phase_t  nx_phase;
	logic [1:0]       nx_hcnt;
	logic [15:0]      nx_acc;
	logic [9:0]       nx_hs;
	logic [8:0]       nx_bc;

	jsu_pkg::out_t    buf_q [jsu_pkg::BUF_DEPTH];
	jsu_pkg::out_t    buf_d [jsu_pkg::BUF_DEPTH];
	logic [2:0]       cnt_q;
	logic [2:0]       cnt_d;
	logic [2:0]       base;

	logic             take;
	logic             in_acc;

	logic [7:0]       c;
	logic [3:0]       hex_d;
	logic             hex_ok;
	logic [15:0]      hex_v;
	logic [7:0]       esc_byte;
	logic             esc_ok;
	logic [20:0]      cp;
	logic [7:0]       enc_b [4];
	logic [2:0]       enc_n;
	logic [9:0]       lim;

	jsu_pkg::act_t    act;
	logic [1:0]       act_err;
	logic [8:0]       act_base;
	logic             act_raw;
	logic [7:0]       raw_byte;
	logic [2:0]       act_n;

	jsu_pkg::out_t    new_res [4];
	logic [2:0]       new_n;

	assign c         = in_data.in_byte;
	assign out_valid = (cnt_q != 3'd0);
	assign out_data  = buf_q[0];
	assign take      = out_valid && !out_stall;
	assign in_stall  = (cnt_q > 3'd1);
	assign in_acc    = in_valid && !in_stall;
	assign base      = cnt_q - {2'b00, take};

	assign lim = (int'(cap_q) < jsu_pkg::MAX_CAPACITY) ? {1'b0, cap_q}
	                                                   : 10'(jsu_pkg::MAX_CAPACITY);

	always_comb begin
		hex_ok = 1'b1;
		hex_d  = 4'd0;
		case (c) inside
			[8'h30:8'h39]: hex_d = c[3:0];
			[8'h61:8'h66], [8'h41:8'h46]: hex_d = 4'(c[3:0] + 4'd9);
			default: hex_ok = 1'b0;
		endcase
	end

	assign hex_v = {acc_q[11:0], hex_d};

	always_comb begin
		esc_ok   = 1'b1;
		esc_byte = c;
		case (c)
			jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: esc_byte = c;
			jsu_pkg::CH_B: esc_byte = 8'h08;
			jsu_pkg::CH_F: esc_byte = 8'h0C;
			jsu_pkg::CH_N: esc_byte = 8'h0A;
			jsu_pkg::CH_R: esc_byte = 8'h0D;
			jsu_pkg::CH_T: esc_byte = 8'h09;
			default: esc_ok = 1'b0;
		endcase
	end

	assign cp = (phase_q == jsu_pkg::PH_HEX2) ? 21'h10000 + {1'b0, hs_q, hex_v[9:0]}
	                                         : {5'd0, hex_v};

	always_comb begin
		enc_b[0] = 8'h00;
		enc_b[1] = 8'h00;
		enc_b[2] = 8'h00;
		enc_b[3] = 8'h00;
		if (cp <= 21'h7F) begin
			enc_b[0] = cp[7:0];
			enc_n    = 3'd1;
		end else if (cp <= 21'h7FF) begin
			enc_b[0] = {3'b110, cp[10:6]};
			enc_b[1] = {2'b10, cp[5:0]};
			enc_n    = 3'd2;
		end else if (cp <= 21'hFFFF) begin
			enc_b[0] = {4'b1110, cp[15:12]};
			enc_b[1] = {2'b10, cp[11:6]};
			enc_b[2] = {2'b10, cp[5:0]};
			enc_n    = 3'd3;
		end else begin
			enc_b[0] = {5'b11110, cp[20:18]};
			enc_b[1] = {2'b10, cp[17:12]};
			enc_b[2] = {2'b10, cp[11:6]};
			enc_b[3] = {2'b10, cp[5:0]};
			enc_n    = 3'd4;
		end
	end

	// next state
	always_comb begin
		logic go_idle;
		logic start_ok;
		go_idle   = 1'b0;
		start_ok  = 1'b0;
		nx_active = active_q;
		nx_phase  = phase_q;
		nx_hcnt   = hcnt_q;
		nx_acc    = acc_q;
		nx_hs     = hs_q;
		nx_bc     = bc_q;
		act       = jsu_pkg::ACT_NONE;
		act_err   = jsu_pkg::ERR_NONE;
		act_base  = bc_q;
		act_raw   = 1'b0;
		raw_byte  = c;
		act_n     = 3'd0;
		if (in_data.start_req) begin
			go_idle  = 1'b1;
			nx_bc    = 9'd0;
			act_base = 9'd0;
			if (in_data.end_of_input || c != jsu_pkg::CH_QUOTE) begin
				act     = jsu_pkg::ACT_ERROR;
				act_err = jsu_pkg::ERR_MALFORMED;
			end else begin
				start_ok = 1'b1;
			end
		end else if (!active_q) begin
			act = jsu_pkg::ACT_NONE;
		end else if (in_data.end_of_input) begin
			act     = jsu_pkg::ACT_ERROR;
			act_err = jsu_pkg::ERR_MALFORMED;
			go_idle = 1'b1;
		end else begin
			case (phase_q)
				jsu_pkg::PH_PLAIN: begin
					if (c == jsu_pkg::CH_QUOTE) begin
						act     = jsu_pkg::ACT_CLOSE;
						go_idle = 1'b1;
					end else if (c < jsu_pkg::CH_SPACE) begin
						act     = jsu_pkg::ACT_ERROR;
						act_err = jsu_pkg::ERR_MALFORMED;
						go_idle = 1'b1;
					end else if (c == jsu_pkg::CH_BSL) begin
						nx_phase = jsu_pkg::PH_ESC;
					end else begin
						act     = jsu_pkg::ACT_BYTES;
						act_raw = 1'b1;
					end
				end
				jsu_pkg::PH_ESC: begin
					if (c == jsu_pkg::CH_U) begin
						nx_phase = jsu_pkg::PH_HEX1;
						nx_hcnt  = 2'd0;
						nx_acc   = 16'd0;
					end else if (esc_ok) begin
						nx_phase = jsu_pkg::PH_PLAIN;
						act      = jsu_pkg::ACT_BYTES;
						act_raw  = 1'b1;
						raw_byte = esc_byte;
					end else begin
						act     = jsu_pkg::ACT_ERROR;
						act_err = jsu_pkg::ERR_MALFORMED;
						go_idle = 1'b1;
					end
				end
				jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
					if (!hex_ok) begin
						act     = jsu_pkg::ACT_ERROR;
						act_err = jsu_pkg::ERR_MALFORMED;
						go_idle = 1'b1;
					end else if (hcnt_q != 2'd3) begin
						nx_acc  = hex_v;
						nx_hcnt = hcnt_q + 2'd1;
					end else begin
						nx_hcnt = 2'd0;
						nx_acc  = 16'd0;
						if (phase_q == jsu_pkg::PH_HEX1) begin
							if (hex_v inside {[16'hD800:16'hDBFF]}) begin
								nx_hs    = hex_v[9:0];
								nx_phase = jsu_pkg::PH_LOW_BS;
							end else if (hex_v inside {[16'hDC00:16'hDFFF]}) begin
								act     = jsu_pkg::ACT_ERROR;
								act_err = jsu_pkg::ERR_MALFORMED;
								go_idle = 1'b1;
							end else begin
								nx_phase = jsu_pkg::PH_PLAIN;
								act      = jsu_pkg::ACT_BYTES;
							end
						end else if (hex_v inside {[16'hDC00:16'hDFFF]}) begin
							nx_phase = jsu_pkg::PH_PLAIN;
							nx_hs    = 10'd0;
							act      = jsu_pkg::ACT_BYTES;
						end else begin
							act     = jsu_pkg::ACT_ERROR;
							act_err = jsu_pkg::ERR_MALFORMED;
							go_idle = 1'b1;
						end
					end
				end
				jsu_pkg::PH_LOW_BS: begin
					if (c == jsu_pkg::CH_BSL) begin
						nx_phase = jsu_pkg::PH_LOW_U;
					end else begin
						act     = jsu_pkg::ACT_ERROR;
						act_err = jsu_pkg::ERR_MALFORMED;
						go_idle = 1'b1;
					end
				end
				jsu_pkg::PH_LOW_U: begin
					if (c == jsu_pkg::CH_U) begin
						nx_phase = jsu_pkg::PH_HEX2;
						nx_hcnt  = 2'd0;
						nx_acc   = 16'd0;
					end else begin
						act     = jsu_pkg::ACT_ERROR;
						act_err = jsu_pkg::ERR_MALFORMED;
						go_idle = 1'b1;
					end
				end
				default: begin
					act     = jsu_pkg::ACT_ERROR;
					act_err = jsu_pkg::ERR_MALFORMED;
					go_idle = 1'b1;
				end
			endcase
		end
		if (act == jsu_pkg::ACT_BYTES) begin
			act_n = act_raw ? 3'd1 : enc_n;
			if ({1'b0, bc_q} + {7'd0, act_n} > lim) begin
				act     = jsu_pkg::ACT_ERROR;
				act_err = jsu_pkg::ERR_TOO_LONG;
				go_idle = 1'b1;
			end else begin
				nx_bc = 9'(bc_q + {6'd0, act_n});
			end
		end
		if (go_idle) begin
			nx_active = 1'b0;
			nx_phase  = jsu_pkg::PH_PLAIN;
			nx_hcnt   = 2'd0;
			nx_acc    = 16'd0;
			nx_hs     = 10'd0;
		end
		if (start_ok) begin
			nx_active = 1'b1;
		end
	end

	// result beats for the accepted item
	always_comb begin
		new_n = 3'd0;
		for (int i = 0; i < 4; i++) begin
			new_res[i]                = '0;
			new_res[i].decoded_length = act_base;
		end
		case (act)
			jsu_pkg::ACT_BYTES: begin
				new_n = act_n;
				for (int i = 0; i < 4; i++) begin
					if (act_raw) begin
						new_res[i].out_byte = (i == 0) ? raw_byte : 8'h00;
					end else begin
						new_res[i].out_byte = enc_b[i];
					end
					new_res[i].kind           = jsu_pkg::KIND_BYTE;
					new_res[i].decoded_length = 9'(act_base + 9'(i + 1));
					new_res[i].last           = (3'(i + 1) == act_n);
				end
			end
			jsu_pkg::ACT_CLOSE: begin
				new_n           = 3'd1;
				new_res[0].kind = jsu_pkg::KIND_CLOSE;
				new_res[0].last = 1'b1;
			end
			jsu_pkg::ACT_ERROR: begin
				new_n                 = 3'd1;
				new_res[0].kind       = jsu_pkg::KIND_ERROR;
				new_res[0].error_code = act_err;
				new_res[0].last       = 1'b1;
			end
			default: new_n = 3'd0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < jsu_pkg::BUF_DEPTH; i++) begin
			if (take && i < jsu_pkg::BUF_DEPTH - 1) begin
				buf_d[i] = buf_q[i + 1];
			end else begin
				buf_d[i] = buf_q[i];
			end
		end
		if (in_acc) begin
			for (int j = 0; j < 4; j++) begin
				if (3'(j) < new_n) begin
					buf_d[3'(j) + base] = new_res[j];
				end
			end
			cnt_d = base + new_n;
		end else begin
			cnt_d = base;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < jsu_pkg::BUF_DEPTH; i++) begin
			buf_q[i] <= buf_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 3'd0;
			cap_q    <= jsu_pkg::CAP_RESET;
			active_q <= 1'b0;
			phase_q  <= jsu_pkg::PH_PLAIN;
			hcnt_q   <= 2'd0;
			acc_q    <= 16'd0;
			hs_q     <= 10'd0;
			bc_q     <= 9'd0;
		end else begin
			cnt_q <= cnt_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (in_acc) begin
				active_q <= nx_active;
				phase_q  <= nx_phase;
				hcnt_q   <= nx_hcnt;
				acc_q    <= nx_acc;
				hs_q     <= nx_hs;
				bc_q     <= nx_bc;
			end
		end
	end

	a_close_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != jsu_pkg::KIND_BYTE |-> out_data.last)
		else $error("close or error beat without last");

	a_follower_buffered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> cnt_q >= 3'd2)
		else $error("non-last beat with no following beat buffered");

	a_idle_plain: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> phase_q == jsu_pkg::PH_PLAIN && hcnt_q == 2'd0)
		else $error("idle with escape state left over");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == jsu_pkg::KIND_ERROR |->
		out_data.error_code != jsu_pkg::ERR_NONE)
		else $error("error beat without error code");

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(jsu_pkg::BUF_DEPTH))
		else $error("result buffer overflow");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import jsu_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	typedef struct {
		in_t  beat;
		bit   typed;
		out_t want;
	} vec_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_t        in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_t       out_data;
	logic       cfg_we = 1'b0;
	logic [8:0] cfg_wdata = '0;

	json_string_unescaper dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// decoder shadow state
	bit         str_open;
	phase_t     ph;
	bit [1:0]   hex_n;
	bit [15:0]  hex_acc;
	bit [9:0]   hi_bits;
	bit [8:0]   nbytes;
	bit [8:0]   cap_reg = CAP_RESET;

	out_t       step_out[$];
	out_t       due_q[$];
	in_t        beat_q[$];
	vec_t       script[$];

	bit         steady;
	int         miss_cnt;
	int         in_beats;
	int         live_beats;
	int         res_beats;
	int         closes_seen;
	int         errors_seen;
	int         quiet;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void put_out(bit [7:0] ob, bit [1:0] k, bit [1:0] e, bit [8:0] len);
		step_out.push_back(out_t'{out_byte: ob, kind: k, error_code: e,
			decoded_length: len, last: 1'b0});
	endfunction

	function automatic void to_idle();
		str_open = 1'b0;
		ph = PH_PLAIN;
		hex_n = '0;
		hex_acc = '0;
		hi_bits = '0;
	endfunction

	function automatic void fail(bit [1:0] e);
		put_out(8'h00, KIND_ERROR, e, nbytes);
		to_idle();
	endfunction

	function automatic void put_seq(bit [7:0] s [4], int n);
		int lim;
		lim = (cap_reg < MAX_CAPACITY) ? int'(cap_reg) : MAX_CAPACITY;
		if (int'(nbytes) + n > lim) begin
			fail(ERR_TOO_LONG);
			return;
		end
		for (int i = 0; i < n; i++) begin
			nbytes++;
			put_out(s[i], KIND_BYTE, ERR_NONE, nbytes);
		end
	endfunction

	function automatic void put_cp(bit [20:0] cp);
		bit [7:0] s [4];
		int n;
		s = '{default: 8'h00};
		if (cp <= 21'h7F) begin
			s[0] = cp[7:0];
			n = 1;
		end else if (cp <= 21'h7FF) begin
			s[0] = 8'hC0 | cp[10:6];
			s[1] = 8'h80 | cp[5:0];
			n = 2;
		end else if (cp <= 21'hFFFF) begin
			s[0] = 8'hE0 | cp[15:12];
			s[1] = 8'h80 | cp[11:6];
			s[2] = 8'h80 | cp[5:0];
			n = 3;
		end else begin
			s[0] = 8'hF0 | cp[20:18];
			s[1] = 8'h80 | cp[17:12];
			s[2] = 8'h80 | cp[11:6];
			s[3] = 8'h80 | cp[5:0];
			n = 4;
		end
		put_seq(s, n);
	endfunction

	function automatic int hex_val(bit [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return 16;
	endfunction

	function automatic void step_string(bit [7:0] c);
		bit [7:0] s [4];
		bit [15:0] v;
		int d;
		s = '{default: 8'h00};
		case (ph)
			PH_PLAIN: begin
				if (c == CH_QUOTE) begin
					put_out(8'h00, KIND_CLOSE, ERR_NONE, nbytes);
					to_idle();
				end else if (c < CH_SPACE) begin
					fail(ERR_MALFORMED);
				end else if (c == CH_BSL) begin
					ph = PH_ESC;
				end else begin
					s[0] = c;
					put_seq(s, 1);
				end
			end
			PH_ESC: begin
				case (c)
					CH_QUOTE, CH_BSL, CH_SLASH: s[0] = c;
					CH_B: s[0] = 8'h08;
					CH_F: s[0] = 8'h0C;
					CH_N: s[0] = 8'h0A;
					CH_R: s[0] = 8'h0D;
					CH_T: s[0] = 8'h09;
					CH_U: begin
						ph = PH_HEX1;
						hex_n = '0;
						hex_acc = '0;
						return;
					end
					default: begin
						fail(ERR_MALFORMED);
						return;
					end
				endcase
				ph = PH_PLAIN;
				put_seq(s, 1);
			end
			PH_HEX1, PH_HEX2: begin
				d = hex_val(c);
				if (d > 15) begin
					fail(ERR_MALFORMED);
					return;
				end
				v = {hex_acc[11:0], 4'(d)};
				if (hex_n < 2'd3) begin
					hex_acc = v;
					hex_n++;
					return;
				end
				hex_n = '0;
				hex_acc = '0;
				if (ph == PH_HEX1) begin
					if (v >= 16'hD800 && v <= 16'hDBFF) begin
						hi_bits = v[9:0];
						ph = PH_LOW_BS;
					end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
						fail(ERR_MALFORMED);
					end else begin
						ph = PH_PLAIN;
						put_cp(21'(v));
					end
				end else if (v < 16'hDC00 || v > 16'hDFFF) begin
					fail(ERR_MALFORMED);
				end else begin
					ph = PH_PLAIN;
					put_cp(21'h10000 + 21'({hi_bits, v[9:0]}));
					hi_bits = '0;
				end
			end
			PH_LOW_BS: begin
				if (c != CH_BSL) fail(ERR_MALFORMED);
				else ph = PH_LOW_U;
			end
			PH_LOW_U: begin
				if (c != CH_U) begin
					fail(ERR_MALFORMED);
				end else begin
					ph = PH_HEX2;
					hex_n = '0;
					hex_acc = '0;
				end
			end
			default: fail(ERR_MALFORMED);
		endcase
	endfunction

	function automatic void decode_beat(in_t b);
		step_out.delete();
		if (b.start_req) begin
			to_idle();
			nbytes = '0;
			if (b.end_of_input || b.in_byte != CH_QUOTE) fail(ERR_MALFORMED);
			else str_open = 1'b1;
		end else if (str_open) begin
			if (b.end_of_input) fail(ERR_MALFORMED);
			else step_string(b.in_byte);
		end
		if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
	endfunction

	task automatic report_miss(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		miss_cnt++;
	endtask

	task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
		if (got !== want) report_miss($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic send_beat(input in_t b, input bit typed, input out_t want);
		bit live;
		while (!steady && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		live = b.start_req || str_open;
		decode_beat(b);
		if (typed) due_q.push_back(want);
		else foreach (step_out[i]) due_q.push_back(step_out[i]);
		if (live) live_beats++;
		in_beats++;
	endtask

	task automatic send_queued();
		foreach (beat_q[i]) send_beat(beat_q[i], 1'b0, '0);
		beat_q.delete();
	endtask

	task automatic set_capacity(input bit [8:0] v);
		in_valid <= 1'b0;
		while (due_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = v;
	endtask

	function automatic void row(bit [7:0] c, bit st = 0, bit eo = 0, bit typed = 0,
		bit [1:0] k = KIND_BYTE, bit [1:0] e = ERR_NONE, bit [8:0] len = 0);
		vec_t v;
		v.beat = in_t'{in_byte: c, start_req: st, end_of_input: eo};
		v.typed = typed;
		v.want = out_t'{out_byte: 8'h00, kind: k, error_code: e, decoded_length: len,
			last: 1'b1};
		script.push_back(v);
	endfunction

	function automatic void push_raw(bit [7:0] c, bit st = 0, bit eo = 0);
		beat_q.push_back(in_t'{in_byte: c, start_req: st, end_of_input: eo});
	endfunction

	function automatic bit [7:0] hex_char(bit [3:0] n);
		if (n < 10) return "0" + n;
		return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
	endfunction

	function automatic void push_quad(bit [15:0] v);
		push_raw(CH_BSL);
		push_raw(CH_U);
		for (int i = 3; i >= 0; i--) push_raw(hex_char(v[4 * i +: 4]));
	endfunction

	function automatic bit [7:0] plain_char();
		bit [7:0] c;
		do c = 8'($urandom_range(8'h20, 8'hFF));
		while (c == CH_QUOTE || c == CH_BSL);
		return c;
	endfunction

	function automatic bit [7:0] non_hex();
		bit [7:0] c;
		do c = 8'($urandom);
		while (hex_val(c) < 16);
		return c;
	endfunction

	function automatic void push_token();
		int pick;
		bit [15:0] v;
		pick = $urandom_range(99);
		if (pick < 40) begin
			push_raw(plain_char());
		end else if (pick < 60) begin
			push_raw(CH_BSL);
			case ($urandom_range(7))
				0: push_raw(CH_QUOTE);
				1: push_raw(CH_BSL);
				2: push_raw(CH_SLASH);
				3: push_raw(CH_B);
				4: push_raw(CH_F);
				5: push_raw(CH_N);
				6: push_raw(CH_R);
				default: push_raw(CH_T);
			endcase
		end else if (pick < 78) begin
			case ($urandom_range(2))
				0: v = 16'($urandom_range(0, 16'h7F));
				1: v = 16'($urandom_range(16'h80, 16'h7FF));
				default: begin
					do v = 16'($urandom_range(16'h800, 16'hFFFF));
					while (v >= 16'hD800 && v <= 16'hDFFF);
				end
			endcase
			push_quad(v);
		end else begin
			push_quad(16'($urandom_range(16'hD800, 16'hDBFF)));
			push_quad(16'($urandom_range(16'hDC00, 16'hDFFF)));
		end
	endfunction

	function automatic void push_fault(int f);
		bit [7:0] c;
		bit [15:0] v;
		int k;
		case (f)
			0: push_raw(8'($urandom_range(0, 8'h1F)));
			1: begin
				do c = 8'($urandom);
				while (c inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
				push_raw(CH_BSL);
				push_raw(c);
			end
			2: begin
				if ($urandom_range(1)) push_quad(16'($urandom_range(16'hD800, 16'hDBFF)));
				push_raw(CH_BSL);
				push_raw(CH_U);
				k = $urandom_range(3);
				for (int i = 0; i < k; i++) push_raw(hex_char(4'($urandom)));
				push_raw(non_hex());
			end
			3: push_quad(16'($urandom_range(16'hDC00, 16'hDFFF)));
			4: begin
				push_quad(16'($urandom_range(16'hD800, 16'hDBFF)));
				do c = 8'($urandom);
				while (c == CH_BSL);
				push_raw(c);
			end
			5: begin
				push_quad(16'($urandom_range(16'hD800, 16'hDBFF)));
				push_raw(CH_BSL);
				do c = 8'($urandom);
				while (c == CH_U);
				push_raw(c);
			end
			6: begin
				push_quad(16'($urandom_range(16'hD800, 16'hDBFF)));
				do v = 16'($urandom);
				while (v >= 16'hDC00 && v <= 16'hDFFF);
				push_quad(v);
			end
			7: push_raw(8'($urandom), 1'b0, 1'b1);
			8: push_raw(CH_QUOTE, 1'b1, 1'b0);
			default: begin
				if ($urandom_range(1)) begin
					push_raw(8'($urandom), 1'b1, 1'b1);
				end else begin
					do c = 8'($urandom);
					while (c == CH_QUOTE);
					push_raw(c, 1'b1, 1'b0);
				end
			end
		endcase
	endfunction

	function automatic void build_string();
		int ntok;
		int f;
		int at;
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 3)) push_raw(8'($urandom), 1'b0, 1'($urandom));
		end
		push_raw(CH_QUOTE, 1'b1, 1'b0);
		ntok = $urandom_range(0, 6);
		f = ($urandom_range(99) < 25) ? $urandom_range(0, 9) : -1;
		at = $urandom_range(0, ntok);
		for (int i = 0; i <= ntok; i++) begin
			if (i == at && f >= 0) begin
				push_fault(f);
				if (f != 8) return;
			end
			if (i < ntok) push_token();
		end
		push_raw(CH_QUOTE);
	endfunction

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 29);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			res_beats++;
			if (due_q.size() == 0) begin
				report_miss($sformatf("unexpected beat %p", out_data));
			end else begin
				if (due_q[0].kind == KIND_CLOSE) closes_seen++;
				if (due_q[0].kind == KIND_ERROR) errors_seen++;
				check_field("out_byte", 9'(out_data.out_byte), 9'(due_q[0].out_byte));
				check_field("kind", 9'(out_data.kind), 9'(due_q[0].kind));
				check_field("error_code", 9'(out_data.error_code), 9'(due_q[0].error_code));
				check_field("decoded_length", out_data.decoded_length,
					due_q[0].decoded_length);
				check_field("last", 9'(out_data.last), 9'(due_q[0].last));
				void'(due_q.pop_front());
			end
		end
	end

	initial begin
		bit [8:0] plan [7];
		to_idle();
		nbytes = '0;
		plan = '{9'd0, 9'd1, 9'd4, 9'd511, 9'($urandom_range(2, 40)), 9'd256,
			9'($urandom_range(1, 256))};

		row("A", 1, 0, 1, KIND_ERROR, ERR_MALFORMED, 0);
		row(CH_QUOTE, 1, 1, 1, KIND_ERROR, ERR_MALFORMED, 0);
		row("A");
		row(CH_QUOTE, 1);
		row(8'hFF);
		row(CH_BSL); row(CH_U); row("D"); row("B"); row("f"); row("F");
		row(CH_BSL); row(CH_U); row("d"); row("f"); row("f"); row("f");
		row(CH_QUOTE, 0, 0, 1, KIND_CLOSE, ERR_NONE, 5);
		row(CH_QUOTE, 1);
		row(CH_BSL); row(CH_U); row("D"); row("C"); row("0");
		row("0", 0, 0, 1, KIND_ERROR, ERR_MALFORMED, 0);
		row(CH_QUOTE, 1);
		row(8'h7F);
		row(CH_QUOTE, 1);
		row(8'h1F, 0, 0, 1, KIND_ERROR, ERR_MALFORMED, 0);
		row(CH_QUOTE, 1);
		row(8'h00, 0, 1, 1, KIND_ERROR, ERR_MALFORMED, 0);

		@(posedge arst_n);
		@(posedge clk);
		foreach (script[i]) send_beat(script[i].beat, script[i].typed, script[i].want);

		for (int p = 0; p < 7; p++) begin
			set_capacity(plan[p]);
			steady = (p == 5);
			live_beats = 0;
			while (live_beats < 34) begin
				build_string();
				send_queued();
			end
		end
		steady = 1'b0;

		in_valid <= 1'b0;
		while (due_q.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("covered %0d input beats and %0d result beats (%0d closes, %0d errors)",
			in_beats, res_beats, closes_seen, errors_seen);
		$display("capacities 256, 0, 1, 4, 511, 256 and two random values");
		if (miss_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
